[rtl/bcwp_pkg.sv]
// Package for the battery charge window policy block.
// Holds the shared types, register index codes, reset values and field widths.
// No dependencies.
package bcwp_pkg;

    localparam int MV_W    = 16;
    localparam int TIME_W  = 48;
    localparam int LEN_W   = 32;
    localparam int STRK_W  = 4;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 3;
    localparam int IN_DATA_W  = 72;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 8;

    localparam logic [MV_W-1:0]   START_LEVEL_RST  = 16'd3900;
    localparam logic [MV_W-1:0]   FORCE_LEVEL_RST  = 16'd4000;
    localparam logic [MV_W-1:0]   SAFETY_LEVEL_RST = 16'd3500;
    localparam logic [MV_W-1:0]   RESUME_LEVEL_RST = 16'd3800;
    localparam logic [LEN_W-1:0]  WINDOW_LEN_RST   = 32'd1200000;
    localparam logic [STRK_W-1:0] CONFIRM_RST      = 4'd3;
    localparam logic [STRK_W-1:0] STREAK_MAX       = 4'd15;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_ENABLE  = 2'd1,
        CMD_DISABLE = 2'd2
    } t_cmd;

    typedef enum logic [IDX_W-1:0] {
        REG_START_LEVEL  = 3'd0,
        REG_FORCE_LEVEL  = 3'd1,
        REG_SAFETY_LEVEL = 3'd2,
        REG_RESUME_LEVEL = 3'd3,
        REG_WINDOW_LEN   = 3'd4,
        REG_CONFIRM      = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [MV_W-1:0]   start_level_mv;
        logic [MV_W-1:0]   force_level_mv;
        logic [MV_W-1:0]   safety_level_mv;
        logic [MV_W-1:0]   resume_level_mv;
        logic [LEN_W-1:0]  window_length_ms;
        logic [STRK_W-1:0] confirm_count;
    } t_cfg;

    typedef struct packed {
        logic              mode;
        logic [MV_W-1:0]   battery_mv;
        logic              supply_present;
        logic              reading_valid;
        logic [TIME_W-1:0] now_ms;
    } t_item;

    typedef struct packed {
        t_cmd              charger_command;
        logic              window_active;
        logic              safety_active;
        logic [STRK_W-1:0] low_streak;
    } t_result;

endpackage

[rtl/bcwp_cfg_regs.sv]
// Configuration register file of the battery charge window policy block.
// Depends on bcwp_pkg for the register codes, widths and reset values.
module bcwp_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bcwp_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [bcwp_pkg::CFG_W-1:0]   i_cfg_data,
    output bcwp_pkg::t_cfg               o_cfg
);
    import bcwp_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_level_mv   <= START_LEVEL_RST;
            r_cfg.force_level_mv   <= FORCE_LEVEL_RST;
            r_cfg.safety_level_mv  <= SAFETY_LEVEL_RST;
            r_cfg.resume_level_mv  <= RESUME_LEVEL_RST;
            r_cfg.window_length_ms <= WINDOW_LEN_RST;
            r_cfg.confirm_count    <= CONFIRM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_START_LEVEL:  r_cfg.start_level_mv   <= i_cfg_data[MV_W-1:0];
                REG_FORCE_LEVEL:  r_cfg.force_level_mv   <= i_cfg_data[MV_W-1:0];
                REG_SAFETY_LEVEL: r_cfg.safety_level_mv  <= i_cfg_data[MV_W-1:0];
                REG_RESUME_LEVEL: r_cfg.resume_level_mv  <= i_cfg_data[MV_W-1:0];
                REG_WINDOW_LEN:   r_cfg.window_length_ms <= i_cfg_data[LEN_W-1:0];
                REG_CONFIRM:      r_cfg.confirm_count    <= i_cfg_data[STRK_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/bcwp_policy_core.sv]
// Policy state and the combinational decision logic of the charge window policy.
// Depends on bcwp_pkg for the item, result and configuration types.
module bcwp_policy_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_eval,
    input  bcwp_pkg::t_item   i_item,
    input  bcwp_pkg::t_cfg    i_cfg,
    output bcwp_pkg::t_result o_result
);
    import bcwp_pkg::*;

    logic              r_active;
    logic              r_safety;
    logic [TIME_W-1:0] r_win_start;
    logic [STRK_W-1:0] r_streak;

    logic              n_active;
    logic              n_safety;
    logic [TIME_W-1:0] n_win_start;
    logic [STRK_W-1:0] n_streak;

    logic [TIME_W-1:0] w_elapsed;
    logic [STRK_W-1:0] w_streak_inc;
    t_cmd              w_cmd;

    // Elapsed window time wraps with the timestamp.
    assign w_elapsed    = i_item.now_ms - r_win_start;
    assign w_streak_inc = (r_streak < STREAK_MAX) ? r_streak + 1'b1 : r_streak;

    always_comb begin
        n_active    = r_active;
        n_safety    = r_safety;
        n_win_start = r_win_start;
        n_streak    = r_streak;
        w_cmd       = CMD_NONE;
        if (i_item.reading_valid) begin
            if (i_item.supply_present && (i_item.battery_mv < i_cfg.force_level_mv)) begin
                n_active    = 1'b1;
                n_win_start = i_item.now_ms;
                n_safety    = 1'b0;
                w_cmd       = CMD_ENABLE;
            end else if (!i_item.mode) begin
                if (i_item.battery_mv < i_cfg.safety_level_mv) begin
                    n_safety    = 1'b1;
                    n_active    = 1'b1;
                    n_win_start = i_item.now_ms;
                    w_cmd       = CMD_ENABLE;
                end else if (i_item.battery_mv < i_cfg.start_level_mv) begin
                    n_active    = 1'b1;
                    n_win_start = i_item.now_ms;
                    w_cmd       = CMD_ENABLE;
                end else begin
                    n_active = 1'b0;
                    w_cmd    = CMD_DISABLE;
                end
            end else if (r_safety) begin
                if (i_item.battery_mv >= i_cfg.resume_level_mv) begin
                    n_safety    = 1'b0;
                    n_active    = 1'b1;
                    n_win_start = i_item.now_ms;
                end
            end else if (r_active) begin
                if (w_elapsed >= {{(TIME_W-LEN_W){1'b0}}, i_cfg.window_length_ms}) begin
                    n_active = 1'b0;
                    n_streak = '0;
                    w_cmd    = CMD_DISABLE;
                end
            end else if (i_item.battery_mv < i_cfg.safety_level_mv) begin
                n_safety    = 1'b1;
                n_active    = 1'b1;
                n_win_start = i_item.now_ms;
                w_cmd       = CMD_ENABLE;
            end else if (i_item.battery_mv < i_cfg.start_level_mv) begin
                n_streak = w_streak_inc;
                if (w_streak_inc >= i_cfg.confirm_count) begin
                    n_active    = 1'b1;
                    n_win_start = i_item.now_ms;
                    n_streak    = '0;
                    w_cmd       = CMD_ENABLE;
                end
            end else begin
                n_streak = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_safety    <= 1'b0;
            r_win_start <= '0;
            r_streak    <= '0;
        end else if (i_eval) begin
            r_active    <= n_active;
            r_safety    <= n_safety;
            r_win_start <= n_win_start;
            r_streak    <= n_streak;
        end
    end

    // Flags in the result show the state after the evaluation.
    assign o_result.charger_command = w_cmd;
    assign o_result.window_active   = n_active;
    assign o_result.safety_active   = n_safety;
    assign o_result.low_streak      = n_streak;

endmodule

[rtl/battery_charge_window_policy.sv]
// Items pass through the input register and then the result register. Throughput: 1 item
// per cycle unless the result stream stalls; the policy state updates in the same cycle
// that a result is captured, so the next item in the input register already sees it.
// Reset (i_rst_n, synchronous, active low) clears both pipeline valids and the policy
// state, and loads the documented default configuration.
// Depends on bcwp_pkg, bcwp_cfg_regs and bcwp_policy_core.
module battery_charge_window_policy (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [bcwp_pkg::IDX_W-1:0]        i_cfg_index,
    input  logic [bcwp_pkg::CFG_W-1:0]        i_cfg_data,
    // Evaluation stream in.
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // tdata: battery_mv[15:0], supply_present[16], now_ms[64:17], zero fill[71:65]
    input  logic [bcwp_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // tuser: mode[0], reading_valid[1]
    input  logic [bcwp_pkg::IN_USER_W-1:0]    i_s_axis_tuser,
    // Result stream out.
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // tdata: charger_command[1:0], window_active[2], safety_active[3], low_streak[7:4]
    output logic [bcwp_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);
    import bcwp_pkg::*;

    t_cfg    w_cfg;
    t_item   w_item;
    t_result w_result;

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out_result;

    logic    w_in_take;
    logic    w_out_load;

    bcwp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Unpack the input transfer into the item fields.
    always_comb begin
        w_item.mode           = i_s_axis_tuser[0];
        w_item.reading_valid  = i_s_axis_tuser[1];
        w_item.battery_mv     = i_s_axis_tdata[15:0];
        w_item.supply_present = i_s_axis_tdata[16];
        w_item.now_ms         = i_s_axis_tdata[64:17];
    end

    // The held item moves on whenever the result register is empty or is being drained,
    // and the input register refills in that same cycle.
    assign w_out_load      = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_out_load;
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_item <= w_item;
        end
    end

    // The core commits its state exactly when the result of the held item is captured.
    bcwp_policy_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_eval   (w_out_load),
        .i_item   (r_in_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_result <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_result.low_streak,
                              r_out_result.safety_active,
                              r_out_result.window_active,
                              r_out_result.charger_command};

endmodule

[test/tb_battery_charge_window_policy.sv]
// Self-checking testbench for the battery charge window policy block.
// Holds the stream drivers, the policy predictor, the result checker and the test sequence.
// Depends on bcwp_pkg and battery_charge_window_policy.
module tb_battery_charge_window_policy;
    timeunit 1ns;
    timeprecision 1ps;

    import bcwp_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 7;
    // Cycles without any transfer before the run is declared hung. The longest
    // legitimate quiet stretch comes from the result hold-off below.
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;
    // Settle time after draining; the block has two pipeline stages.
    localparam int DRAIN_SETTLE = 4;

    localparam logic MODE_INITIAL  = 1'b0;
    localparam logic MODE_PERIODIC = 1'b1;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;

    logic                  cfg_we    = 1'b0;
    t_cfg_idx              cfg_index = REG_START_LEVEL;
    logic [CFG_W-1:0]      cfg_data  = '0;

    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [IN_DATA_W-1:0]  s_data  = '0;
    logic [IN_USER_W-1:0]  s_user  = '0;

    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [OUT_DATA_W-1:0] m_data;

    battery_charge_window_policy u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        // tdata: battery_mv[15:0], supply_present[16], now_ms[64:17], zero fill[71:65]
        .i_s_axis_tdata  (s_data),
        // tuser: mode[0], reading_valid[1]
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        // tdata: charger_command[1:0], window_active[2], safety_active[3], low_streak[7:4]
        .o_m_axis_tdata  (m_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Predictor copy of the configuration and of the policy state. The block is
    // only reconfigured while idle, so this copy never races the hardware.
    t_cfg policy_cfg = '{START_LEVEL_RST, FORCE_LEVEL_RST, SAFETY_LEVEL_RST,
                         RESUME_LEVEL_RST, WINDOW_LEN_RST, CONFIRM_RST};
    logic              win_active     = 1'b0;
    logic              safety_on      = 1'b0;
    logic [TIME_W-1:0] win_start_ms   = '0;
    logic [STRK_W-1:0] low_streak_cnt = '0;

    // Policy outcomes predicted for accepted evaluations, oldest first.
    t_result policy_outcomes_q[$];

    // Running timestamp of the random evaluation stream.
    logic [TIME_W-1:0] stream_now_ms = '0;

    bit idle_on      = 1'b1;
    int hold_request = 0;

    int sent_count     = 0;
    int checked_count  = 0;
    int settings_count = 0;
    int mismatch_count = 0;
    int enable_count   = 0;
    int disable_count  = 0;
    int none_count     = 0;
    int stall_cycles   = 0;

    // Works out the charger command and the flags for one evaluation and moves
    // the predicted policy state forward.
    function automatic t_result predict_policy(input t_item ev);
        t_result           r;
        logic [TIME_W-1:0] elapsed;
        r.charger_command = CMD_NONE;
        if (ev.reading_valid) begin
            if (ev.supply_present && ev.battery_mv < policy_cfg.force_level_mv) begin
                // External supply with a cell below the force level always wins.
                win_active        = 1'b1;
                win_start_ms      = ev.now_ms;
                safety_on         = 1'b0;
                r.charger_command = CMD_ENABLE;
            end else if (ev.mode == MODE_INITIAL) begin
                // Start-up evaluation: no streak, decide on the reading alone.
                if (ev.battery_mv < policy_cfg.safety_level_mv) begin
                    safety_on         = 1'b1;
                    win_active        = 1'b1;
                    win_start_ms      = ev.now_ms;
                    r.charger_command = CMD_ENABLE;
                end else if (ev.battery_mv < policy_cfg.start_level_mv) begin
                    win_active        = 1'b1;
                    win_start_ms      = ev.now_ms;
                    r.charger_command = CMD_ENABLE;
                end else begin
                    win_active        = 1'b0;
                    r.charger_command = CMD_DISABLE;
                end
            end else if (safety_on) begin
                // Safety charging runs until the resume level, then a timed
                // window takes over without a new charger write.
                if (ev.battery_mv >= policy_cfg.resume_level_mv) begin
                    safety_on    = 1'b0;
                    win_active   = 1'b1;
                    win_start_ms = ev.now_ms;
                end
            end else if (win_active) begin
                elapsed = ev.now_ms - win_start_ms;
                if (elapsed >= TIME_W'(policy_cfg.window_length_ms)) begin
                    win_active        = 1'b0;
                    low_streak_cnt    = '0;
                    r.charger_command = CMD_DISABLE;
                end
            end else if (ev.battery_mv < policy_cfg.safety_level_mv) begin
                safety_on         = 1'b1;
                win_active        = 1'b1;
                win_start_ms      = ev.now_ms;
                r.charger_command = CMD_ENABLE;
            end else if (ev.battery_mv < policy_cfg.start_level_mv) begin
                if (low_streak_cnt < STREAK_MAX) begin
                    low_streak_cnt = low_streak_cnt + 1'b1;
                end
                if (low_streak_cnt >= policy_cfg.confirm_count) begin
                    win_active        = 1'b1;
                    win_start_ms      = ev.now_ms;
                    low_streak_cnt    = '0;
                    r.charger_command = CMD_ENABLE;
                end
            end else begin
                low_streak_cnt = '0;
            end
        end
        r.window_active = win_active;
        r.safety_active = safety_on;
        r.low_streak    = low_streak_cnt;
        return r;
    endfunction

    function automatic t_item make_eval(input logic mode, input logic [MV_W-1:0] mv,
                                        input logic supply, input logic valid,
                                        input logic [TIME_W-1:0] now);
        t_item ev;
        ev.mode           = mode;
        ev.battery_mv     = mv;
        ev.supply_present = supply;
        ev.reading_valid  = valid;
        ev.now_ms         = now;
        return ev;
    endfunction

    // Battery levels cluster around the configured thresholds so that every
    // comparison is hit on both sides; the rest are arbitrary 16-bit values.
    function automatic logic [MV_W-1:0] pick_level();
        logic [MV_W-1:0] base;
        case ($urandom_range(5))
            0:       base = policy_cfg.start_level_mv;
            1:       base = policy_cfg.force_level_mv;
            2:       base = policy_cfg.safety_level_mv;
            3:       base = policy_cfg.resume_level_mv;
            default: return MV_W'($urandom);
        endcase
        return base + MV_W'($urandom_range(6)) - MV_W'(3);
    endfunction

    // Mostly a plausible sequence of periodic ticks with time moving forward,
    // so that streaks build up and windows run out. Some steps land right on
    // the expiry boundary and a few jump to an arbitrary timestamp.
    function automatic t_item random_evaluation();
        t_item             ev;
        logic [TIME_W-1:0] span;
        span = TIME_W'(policy_cfg.window_length_ms);
        case ($urandom_range(19))
            0:       stream_now_ms = TIME_W'({$urandom, $urandom});
            1, 2:    stream_now_ms = win_start_ms + span - TIME_W'(1)
                                     + TIME_W'($urandom_range(2));
            3:       stream_now_ms = stream_now_ms + span + TIME_W'($urandom_range(1000));
            default: stream_now_ms = stream_now_ms
                                     + TIME_W'($urandom_range(policy_cfg.window_length_ms / 6 + 1));
        endcase
        ev.mode           = ($urandom_range(99) < 8) ? MODE_INITIAL : MODE_PERIODIC;
        ev.battery_mv     = pick_level();
        ev.supply_present = ($urandom_range(99) < 20);
        ev.reading_valid  = ($urandom_range(99) < 92);
        ev.now_ms         = stream_now_ms;
        return ev;
    endfunction

    function automatic void report_field(input string field, input logic [3:0] want,
                                         input logic [3:0] got);
        mismatch_count++;
        // Keep the log short if the block is badly broken.
        if (mismatch_count <= 30) begin
            $display("time %0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
        end
    endfunction

    // Offers one evaluation and returns at the edge where it is transferred.
    // The valid is left high so that a following call can keep it asserted
    // without a gap; wait_drained lowers it.
    task automatic send_evaluation(input t_item ev);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(99) < 33) begin
            gap = $urandom_range(4, 1);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {7'b0, ev.now_ms, ev.supply_present, ev.battery_mv};
        s_user  <= {ev.reading_valid, ev.mode};
        do @(posedge i_clk); while (!s_ready);
        policy_outcomes_q.push_back(predict_policy(ev));
        sent_count++;
    endtask

    // Stops offering items and waits until every predicted outcome has been
    // checked, then lets the pipeline settle.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (policy_outcomes_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_START_LEVEL:  policy_cfg.start_level_mv   = value[MV_W-1:0];
            REG_FORCE_LEVEL:  policy_cfg.force_level_mv   = value[MV_W-1:0];
            REG_SAFETY_LEVEL: policy_cfg.safety_level_mv  = value[MV_W-1:0];
            REG_RESUME_LEVEL: policy_cfg.resume_level_mv  = value[MV_W-1:0];
            REG_WINDOW_LEN:   policy_cfg.window_length_ms = value[LEN_W-1:0];
            REG_CONFIRM:      policy_cfg.confirm_count    = value[STRK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_policy_settings(input logic [MV_W-1:0] start_mv,
                                         input logic [MV_W-1:0] force_mv,
                                         input logic [MV_W-1:0] safety_mv,
                                         input logic [MV_W-1:0] resume_mv,
                                         input logic [LEN_W-1:0] length_ms,
                                         input logic [STRK_W-1:0] confirm);
        wait_drained();
        write_register(REG_START_LEVEL, CFG_W'(start_mv));
        write_register(REG_FORCE_LEVEL, CFG_W'(force_mv));
        write_register(REG_SAFETY_LEVEL, CFG_W'(safety_mv));
        write_register(REG_RESUME_LEVEL, CFG_W'(resume_mv));
        write_register(REG_WINDOW_LEN, CFG_W'(length_ms));
        write_register(REG_CONFIRM, CFG_W'(confirm));
        settings_count++;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_evaluation(random_evaluation());
    endtask

    // Walks through every branch of the policy once with the reset settings:
    // invalid reading, streak build-up, window expiry, safety entry and
    // release, every start-up outcome, supply forcing and a timestamp wrap.
    task automatic test_directed_policy();
        logic [TIME_W-1:0] len;
        len = TIME_W'(WINDOW_LEN_RST);
        send_evaluation(make_eval(MODE_PERIODIC, 16'd3700, 1'b1, 1'b0, 48'd10));
        send_evaluation(make_eval(MODE_PERIODIC, 16'd3950, 1'b0, 1'b1, 48'd100));
        send_evaluation(make_eval(MODE_PERIODIC, 16'd3850, 1'b0, 1'b1, 48'd200));
        send_evaluation(make_eval(MODE_PERIODIC, 16'd3850, 1'b0, 1'b1, 48'd300));
        send_evaluation(make_eval(MODE_PERIODIC, 16'd3850, 1'b0, 1'b1, 48'd400));
        send_evaluation(make_eval(MODE_PERIODIC, 16'd3000, 1'b0, 1'b1, 48'd500));
        // One millisecond short of expiry, then exactly at it.
        send_evaluation(make_eval(MODE_PERIODIC, 16'd3000, 1'b0, 1'b1, 48'd399 + len));
        send_evaluation(make_eval(MODE_PERIODIC, 16'd3000, 1'b0, 1'b1, 48'd400 + len));
        send_evaluation(make_eval(MODE_PERIODIC, 16'd3000, 1'b0, 1'b1, 48'd2000000));
        send_evaluation(make_eval(MODE_PERIODIC, 16'd3799, 1'b0, 1'b1, 48'd2050000));
        send_evaluation(make_eval(MODE_PERIODIC, 16'd3800, 1'b0, 1'b1, 48'd2100000));
        send_evaluation(make_eval(MODE_INITIAL, 16'hFFFF, 1'b0, 1'b1, 48'd2200000));
        send_evaluation(make_eval(MODE_INITIAL, 16'd0, 1'b0, 1'b1, 48'd2300000));
        send_evaluation(make_eval(MODE_INITIAL, 16'd3600, 1'b0, 1'b1, 48'd2400000));
        send_evaluation(make_eval(MODE_PERIODIC, 16'd3999, 1'b1, 1'b1, 48'd2500000));
        send_evaluation(make_eval(MODE_PERIODIC, 16'd4000, 1'b1, 1'b1, 48'hFFFF_FFFF_FFFF));
        // A window opened just before the 48-bit wrap must still time out correctly.
        send_evaluation(make_eval(MODE_INITIAL, 16'd3600, 1'b0, 1'b1, 48'hFFFF_FFFF_FFF0));
        send_evaluation(make_eval(MODE_PERIODIC, 16'd3600, 1'b0, 1'b1, 48'h10));
        send_evaluation(make_eval(MODE_PERIODIC, 16'd3600, 1'b0, 1'b1, len - 48'd17));
        send_evaluation(make_eval(MODE_PERIODIC, 16'd3600, 1'b0, 1'b1, len - 48'd16));
        send_evaluation(make_eval(MODE_INITIAL, 16'd3600, 1'b1, 1'b0, 48'd0));
        send_evaluation(make_eval(MODE_PERIODIC, 16'hFFFF, 1'b1, 1'b1, 48'd0));
        send_evaluation(make_eval(MODE_INITIAL, 16'd3999, 1'b1, 1'b1, 48'd5));
    endtask

    // Corner settings: every threshold at zero with a zero-length window, every
    // threshold at full scale with the longest window and longest streak, a
    // streak requirement of zero, and a requirement of one.
    task automatic test_register_extremes();
        apply_policy_settings(16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 4'd1);
        send_random(120);
        apply_policy_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 4'd15);
        send_random(120);
        apply_policy_settings(START_LEVEL_RST, FORCE_LEVEL_RST, SAFETY_LEVEL_RST,
                              RESUME_LEVEL_RST, 32'd5000, 4'd0);
        send_random(120);
        apply_policy_settings(START_LEVEL_RST, FORCE_LEVEL_RST, SAFETY_LEVEL_RST,
                              RESUME_LEVEL_RST, 32'd20000, 4'd1);
        send_random(60);
    endtask

    // Thresholds in a realistic band but in any order relative to each other.
    task automatic test_random_registers();
        repeat (3) begin
            apply_policy_settings(MV_W'($urandom_range(4500, 3000)),
                                  MV_W'($urandom_range(4500, 3000)),
                                  MV_W'($urandom_range(4500, 3000)),
                                  MV_W'($urandom_range(4500, 3000)),
                                  LEN_W'($urandom_range(200000, 1000)),
                                  STRK_W'($urandom_range(15, 1)));
            send_random(120);
        end
    endtask

    // Long random run with the reset settings; the sender stops twice midway
    // and waits for every outstanding result before carrying on.
    task automatic test_random_policy();
        apply_policy_settings(START_LEVEL_RST, FORCE_LEVEL_RST, SAFETY_LEVEL_RST,
                              RESUME_LEVEL_RST, WINDOW_LEN_RST, CONFIRM_RST);
        repeat (3) begin
            send_random(230);
            wait_drained();
        end
    endtask

    // The result side holds off for a long stretch while evaluations keep
    // coming, so the pipeline fills and the input must stall.
    task automatic test_output_backpressure();
        hold_request = HOLD_CYCLES;
        send_random(80);
    endtask

    // Back-to-back transfers on both sides with no idle cycles at all.
    task automatic test_steady_stream();
        idle_on = 1'b0;
        send_random(250);
        idle_on = 1'b1;
    endtask

    // Result checker and receiver. Each transfer on the result stream is
    // compared field by field with the oldest prediction. The ready is redrawn
    // every cycle, except during a requested hold-off, which is counted here.
    initial begin : result_checker
        t_result               want;
        logic [OUT_DATA_W-1:0] got;
        int                    hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_valid && m_ready) begin
                got = m_data;
                if (policy_outcomes_q.size() == 0) begin
                    mismatch_count++;
                    $display("time %0t: unexpected result transfer, expected none, actual 0x%h",
                             $time, got);
                end else begin
                    want = policy_outcomes_q.pop_front();
                    checked_count++;
                    case (want.charger_command)
                        CMD_ENABLE:  enable_count++;
                        CMD_DISABLE: disable_count++;
                        default:     none_count++;
                    endcase
                    if (got[1:0] !== want.charger_command) begin
                        report_field("charger_command", 4'(want.charger_command), 4'(got[1:0]));
                    end
                    if (got[2] !== want.window_active) begin
                        report_field("window_active", 4'(want.window_active), 4'(got[2]));
                    end
                    if (got[3] !== want.safety_active) begin
                        report_field("safety_active", 4'(want.safety_active), 4'(got[3]));
                    end
                    if (got[7:4] !== want.low_streak) begin
                        report_field("low_streak", want.low_streak, got[7:4]);
                    end
                end
            end
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= idle_on ? ($urandom_range(99) >= 33) : 1'b1;
            end
        end
    end

    // Watchdog: any transfer on either stream restarts the count.
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("time %0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_policy();
        test_register_extremes();
        test_random_registers();
        test_random_policy();
        test_output_backpressure();
        test_steady_stream();

        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d evaluations and %0d checked results over %0d register settings.",
                 sent_count, checked_count, settings_count);
        $display("Charger commands: %0d enable, %0d disable, %0d no write; %0d mismatches.",
                 enable_count, disable_count, none_count, mismatch_count);
        if (mismatch_count == 0 && policy_outcomes_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
